// File: rtl/arwpp_pkg.sv
// Shared types and constants for the address range watch pc profiler.
package arwpp_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;

   localparam logic [31:0] PHYS_MASK     = 32'h1FFF_FFFF;
   localparam logic [31:0] BUDGET_RESET  = 32'd400;

   // configuration register indexes
   localparam logic [2:0] CSR_WATCH_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_RANGE_LOW     = 3'd1;
   localparam logic [2:0] CSR_RANGE_HIGH    = 3'd2;
   localparam logic [2:0] CSR_SKIP_LOW      = 3'd3;
   localparam logic [2:0] CSR_SKIP_HIGH     = 3'd4;
   localparam logic [2:0] CSR_RECORD_BUDGET = 3'd5;

   // request item function codes
   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // request payload, lowest field last
   typedef struct packed {
      logic [7:0]  entry_index;
      logic [63:0] stamp;
      logic [31:0] instr_pc;
      logic [31:0] access_addr;
   } req_type;

   // response payload, lowest field last, padded to whole bytes
   typedef struct packed {
      logic [6:0]  pad;
      logic [8:0]  entries_used;
      logic [63:0] entry_last;
      logic [63:0] entry_first;
      logic [63:0] entry_hits;
      logic [31:0] entry_pc;
      logic        entry_valid;
      logic [28:0] phys_addr;
      logic        log_record;
      logic        in_range;
   } rsp_type;

   // one profile table row
   typedef struct packed {
      logic [31:0] pc;
      logic [63:0] first;
      logic [63:0] last;
      logic [63:0] hits;
   } entry_type;

endpackage

// File: rtl/address_range_watch_pc_profiler.sv
// Address range watch with a per-pc profile table kept in a single-port scan memory.

// An access request (tuser 0) is checked against the watch range and skip window and,
// when in range, scans the profile table one entry per cycle through a single read port
// before updating the row of its pc or, while the table has room, appending its pc.
// Out-of-range accesses skip the scan, and table reads (tuser 1) make a single read of
// the table. The request side is ready again once the response has been loaded into the
// response register, so one request is in flight at a time; the response register lets
// the next request be accepted while a finished response still waits to be taken.
module address_range_watch_pc_profiler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // access_addr[31:0], instr_pc[63:32], stamp[127:64], entry_index[135:128]
   input  logic [135:0] req_tdata,
   // func[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // in_range[0], log_record[1], phys_addr[30:2], entry_valid[31], entry_pc[63:32],
   // entry_hits[127:64], entry_first[191:128], entry_last[255:192],
   // entries_used[264:256], zero pad[271:265]
   output logic [271:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wr_data
);
   import arwpp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // configuration
   logic        enable_ff;
   logic [31:0] range_lo_ff, range_hi_ff, skip_lo_ff, skip_hi_ff, budget_ff;

   // control
   logic [2:0]       state_ff, state_in;
   logic [31:0]      logged_ff, logged_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // payload
   logic        func_ff;
   req_type     req_ff;
   logic        hit_ff, hit_in;
   logic        log_ff, log_in;
   logic        ent_vld_ff, ent_vld_in;
   rsp_type     rsp_ff;

   // table memory
   entry_type        mem [TABLE_ENTRIES];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // evaluation of the held request
   logic [31:0] phys;
   logic        in_win;
   logic        skipped;
   logic        can_log;
   logic        pc_match;
   rsp_type     rsp_next;

   assign phys     = req_ff.access_addr & PHYS_MASK;
   assign in_win   = enable_ff && (phys >= range_lo_ff) && (phys < range_hi_ff);
   // wrapping window test
   assign skipped  = (skip_hi_ff != skip_lo_ff) &&
                     ((req_ff.instr_pc - skip_lo_ff) < (skip_hi_ff - skip_lo_ff));
   assign can_log  = in_win && !skipped && (logged_ff < budget_ff);
   assign pc_match = cmp_vld_ff && (rd_data_ff.pc == req_ff.instr_pc);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      state_in   = state_ff;
      logged_in  = logged_ff;
      used_in    = used_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      log_in     = log_ff;
      ent_vld_in = ent_vld_ff;
      rsp_vld_in = rsp_vld_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = cmp_idx_ff;
      wr_data    = '{pc: req_ff.instr_pc, first: rd_data_ff.first,
                     last: req_ff.stamp, hits: rd_data_ff.hits + 64'd1};

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            scan_in = '0;
            if (func_ff == FUNC_READ) begin
               hit_in     = 1'b0;
               log_in     = 1'b0;
               ent_vld_in = ({1'b0, req_ff.entry_index} < used_ff);
               rd_en      = 1'b1;
               rd_addr    = req_ff.entry_index;
               state_in   = ST_RDWAIT;
            end else begin
               hit_in     = in_win;
               log_in     = can_log;
               ent_vld_in = 1'b0;
               if (can_log) begin
                  logged_in = logged_ff + 32'd1;
               end
               state_in = in_win ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            // read at scan_ff while comparing the row fetched last cycle
            if (pc_match) begin
               wr_en    = 1'b1;
               state_in = ST_FINISH;
            end else if (scan_ff == used_ff) begin
               if (used_ff < CNT_W'(TABLE_ENTRIES)) begin
                  wr_en   = 1'b1;
                  wr_addr = used_ff[IDX_W-1:0];
                  wr_data = '{pc: req_ff.instr_pc, first: req_ff.stamp,
                              last: req_ff.stamp, hits: 64'd1};
                  used_in = used_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end else begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         ST_RDWAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_next              = '0;
      rsp_next.entries_used = used_ff;
      if (func_ff == FUNC_ACCESS) begin
         rsp_next.in_range   = hit_ff;
         rsp_next.log_record = log_ff;
         rsp_next.phys_addr  = phys[28:0];
      end else if (ent_vld_ff) begin
         rsp_next.entry_valid = 1'b1;
         rsp_next.entry_pc    = rd_data_ff.pc;
         rsp_next.entry_hits  = rd_data_ff.hits;
         rsp_next.entry_first = rd_data_ff.first;
         rsp_next.entry_last  = rd_data_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         range_lo_ff <= '0;
         range_hi_ff <= '0;
         skip_lo_ff  <= '0;
         skip_hi_ff  <= '0;
         budget_ff   <= BUDGET_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_WATCH_ENABLE:  enable_ff   <= csr_wr_data[0];
            CSR_RANGE_LOW:     range_lo_ff <= csr_wr_data;
            CSR_RANGE_HIGH:    range_hi_ff <= csr_wr_data;
            CSR_SKIP_LOW:      skip_lo_ff  <= csr_wr_data;
            CSR_SKIP_HIGH:     skip_hi_ff  <= csr_wr_data;
            CSR_RECORD_BUDGET: budget_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         logged_ff  <= '0;
         used_ff    <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         logged_ff  <= logged_in;
         used_ff    <= used_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      log_ff     <= log_in;
      ent_vld_ff <= ent_vld_in;
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         req_ff  <= req_tdata;
      end
      if (state_ff == ST_FINISH && (!rsp_vld_ff || rsp_tready)) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // table never overfills
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("table fill count beyond table size");

   // fill count grows by at most one per request and never shrinks
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + CNT_W'(1)))
      else $error("table fill count jumped");

   // the log count only moves when an access is evaluated
   a_logged_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EVAL) |=> (logged_ff == $past(logged_ff)))
      else $error("log count changed outside evaluation");

   // a pending comparison always belongs to a table scan
   a_cmp_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SEARCH) && ({1'b0, cmp_idx_ff} < used_ff))
      else $error("row comparison outside the scan");

endmodule

// File: tb/address_range_watch_pc_profiler_tb.sv
// Testbench for the address range watch pc profiler: directed script, then random phases.
`timescale 1ns / 1ps

module address_range_watch_pc_profiler_tb;
   import arwpp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AT        = 600;
   localparam int QUIET_AFTER    = 1120;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      logic [31:0]  reg_val;
      logic         func;
      logic [31:0]  addr;
      logic [31:0]  pc;
      logic [63:0]  stamp;
      logic [7:0]   idx;
      logic         typed;
      logic         t_in_range;
      logic         t_log;
      logic [28:0]  t_phys;
      logic [8:0]   t_used;
   } stim_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata   = '0;
   logic         req_tuser   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [271:0] rsp_tdata;
   logic         csr_wr_en   = 1'b0;
   logic [2:0]   csr_addr    = '0;
   logic [31:0]  csr_wr_data = '0;

   // shadow of the watch registers and the profile table
   logic        sh_enable;
   logic [31:0] sh_lo, sh_hi, sh_skip_lo, sh_skip_hi, sh_budget;
   logic [31:0] logged_n;
   logic [8:0]  used_n;
   logic [31:0] prof_pc    [TABLE_ENTRIES];
   logic [63:0] prof_first [TABLE_ENTRIES];
   logic [63:0] prof_last  [TABLE_ENTRIES];
   logic [63:0] prof_hits  [TABLE_ENTRIES];

   rsp_type     outcomes_due[$];
   int          mismatch_count  = 0;
   int          responses_taken = 0;
   int          quiet_cycles    = 0;
   int          stall_left      = 0;
   bit          long_hold_done  = 1'b0;
   bit          tx_quiet        = 1'b0;
   logic [63:0] stamp_clock;

   address_range_watch_pc_profiler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic rsp_type predict_outcome(logic func, logic [31:0] addr, logic [31:0] pc,
                                                logic [63:0] stamp, logic [7:0] idx);
      rsp_type     r;
      logic [31:0] phys, pc_off, win_len;
      bit          skipped, found;
      int          i;
      r = '0;
      if (func == FUNC_ACCESS) begin
         phys = addr & PHYS_MASK;
         r.phys_addr = phys[28:0];
         if (sh_enable && phys >= sh_lo && phys < sh_hi) begin
            pc_off  = pc - sh_skip_lo;
            win_len = sh_skip_hi - sh_skip_lo;
            skipped = (sh_skip_hi != sh_skip_lo) && (pc_off < win_len);
            r.in_range = 1'b1;
            if (!skipped && logged_n < sh_budget) begin
               r.log_record = 1'b1;
               logged_n++;
            end
            found = 1'b0;
            for (i = 0; i < used_n; i++) begin
               if (!found && prof_pc[i] == pc) begin
                  prof_last[i] = stamp;
                  prof_hits[i] = prof_hits[i] + 64'd1;
                  found = 1'b1;
               end
            end
            if (!found && used_n < TABLE_ENTRIES) begin
               prof_pc[used_n[7:0]]    = pc;
               prof_first[used_n[7:0]] = stamp;
               prof_last[used_n[7:0]]  = stamp;
               prof_hits[used_n[7:0]]  = 64'd1;
               used_n++;
            end
         end
      end else if (idx < used_n) begin
         r.entry_valid = 1'b1;
         r.entry_pc    = prof_pc[idx];
         r.entry_hits  = prof_hits[idx];
         r.entry_first = prof_first[idx];
         r.entry_last  = prof_last[idx];
      end
      r.entries_used = used_n;
      return r;
   endfunction

   function automatic stim_row_type req_row(logic func, logic [31:0] addr, logic [31:0] pc,
                                            logic [63:0] stamp, logic [7:0] idx);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_REQ;
      r.func  = func;
      r.addr  = addr;
      r.pc    = pc;
      r.stamp = stamp;
      r.idx   = idx;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(logic func, logic [31:0] addr, logic [7:0] idx,
                                              logic in_range, logic log_rec, logic [28:0] phys,
                                              logic [8:0] used);
      stim_row_type r;
      r = req_row(func, addr, 32'h0, 64'h0, idx);
      r.typed      = 1'b1;
      r.t_in_range = in_range;
      r.t_log      = log_rec;
      r.t_phys     = phys;
      r.t_used     = used;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [2:0] reg_idx, logic [31:0] val);
      stim_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.reg_idx = reg_idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %h got %h", $realtime, name, want, got);
      end
   endfunction

   task automatic send_request(input logic func, input logic [31:0] addr, input logic [31:0] pc,
                               input logic [63:0] stamp, input logic [7:0] idx,
                               input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      if (!tx_quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {idx, stamp, pc, addr};
      do @(posedge clock); while (!req_tready);
      predicted = predict_outcome(func, addr, pc, stamp, idx);
      outcomes_due.push_back(typed ? typed_rsp : predicted);
   endtask

   // holds the sender until every response is in and the block has gone quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_WATCH_ENABLE:  sh_enable  = val[0];
         CSR_RANGE_LOW:     sh_lo      = val;
         CSR_RANGE_HIGH:    sh_hi      = val;
         CSR_SKIP_LOW:      sh_skip_lo = val;
         CSR_SKIP_HIGH:     sh_skip_hi = val;
         CSR_RECORD_BUDGET: sh_budget  = val;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_watch(input logic [31:0] en, input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] slo, input logic [31:0] shi,
                            input logic [31:0] budget);
      wait_idle();
      write_csr(CSR_WATCH_ENABLE, en);
      write_csr(CSR_RANGE_LOW, lo);
      write_csr(CSR_RANGE_HIGH, hi);
      write_csr(CSR_SKIP_LOW, slo);
      write_csr(CSR_SKIP_HIGH, shi);
      write_csr(CSR_RECORD_BUDGET, budget);
   endtask

   // mostly in-range accesses from a pc pool, with table reads and raw noise mixed in
   task automatic run_phase(input int count, input logic [31:0] pool_base, input int pool_size);
      int          roll;
      logic [31:0] top, span, phys, addr, pc;
      logic [7:0]  idx;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         top  = (sh_hi > 32'h2000_0000) ? 32'h2000_0000 : sh_hi;
         span = top - sh_lo;
         stamp_clock += 64'($urandom_range(1, 500));
         if (roll < 12) begin
            idx = 8'(($urandom_range(1) == 0) ? $urandom_range(255) : $urandom_range(used_n));
            send_request(FUNC_READ, $urandom, $urandom, rand64(), idx, 1'b0, '0);
         end else if (roll < 22) begin
            send_request(FUNC_ACCESS, $urandom, $urandom, rand64(), 8'($urandom_range(255)),
                         1'b0, '0);
         end else begin
            if (roll < 26)
               phys = sh_lo;
            else if (roll < 30)
               phys = top - 32'd1;
            else
               phys = sh_lo + ($urandom % span);
            addr = {3'($urandom_range(7)), phys[28:0]};
            pc   = pool_base + 32'd4 * $urandom_range(pool_size - 1);
            send_request(FUNC_ACCESS, addr, pc, stamp_clock, 8'($urandom_range(255)),
                         1'b0, '0);
         end
      end
   endtask

   // response side: back-pressure and checking
   always @(posedge clock) begin
      rsp_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         responses_taken++;
         if (outcomes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response with no request outstanding: %h", $realtime, got);
         end else begin
            want = outcomes_due.pop_front();
            check_field("in_range", want.in_range, got.in_range);
            check_field("log_record", want.log_record, got.log_record);
            check_field("phys_addr", want.phys_addr, got.phys_addr);
            check_field("entry_valid", want.entry_valid, got.entry_valid);
            check_field("entry_pc", want.entry_pc, got.entry_pc);
            check_field("entry_hits", want.entry_hits, got.entry_hits);
            check_field("entry_first", want.entry_first, got.entry_first);
            check_field("entry_last", want.entry_last, got.entry_last);
            check_field("entries_used", want.entries_used, got.entries_used);
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && responses_taken >= HOLD_AT) begin
         // long hold so the block backs up and stalls its request side
         long_hold_done <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
         rsp_tready     <= 1'b0;
      end else if (responses_taken < QUIET_AFTER && $urandom_range(3) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type script[$];
      rsp_type      typed_rsp;
      logic [31:0]  lo;

      sh_enable   = 1'b0;
      sh_lo       = '0;
      sh_hi       = '0;
      sh_skip_lo  = '0;
      sh_skip_hi  = '0;
      sh_budget   = BUDGET_RESET;
      logged_n    = '0;
      used_n      = '0;
      stamp_clock = rand64();

      script = '{
         // watch off after reset, empty table
         fixed_row(FUNC_ACCESS, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 29'h1FFF_FFFF, 9'd0),
         fixed_row(FUNC_READ, 32'h0, 8'h00, 1'b0, 1'b0, 29'h0, 9'd0),
         fixed_row(FUNC_READ, 32'h0, 8'hFF, 1'b0, 1'b0, 29'h0, 9'd0),
         csr_row(CSR_WATCH_ENABLE, 32'h1),
         csr_row(CSR_RANGE_LOW, 32'h100),
         csr_row(CSR_RANGE_HIGH, 32'h200),
         csr_row(CSR_SKIP_LOW, 32'h1000),
         csr_row(CSR_SKIP_HIGH, 32'h1010),
         csr_row(CSR_RECORD_BUDGET, 32'd2),
         req_row(FUNC_ACCESS, 32'h0000_0100, 32'h2000, 64'h0, 8'h00),
         req_row(FUNC_ACCESS, 32'h0000_01FF, 32'h1000, 64'h1, 8'h00),
         req_row(FUNC_ACCESS, 32'hE000_0150, 32'h100F, 64'h2, 8'hFF),
         req_row(FUNC_ACCESS, 32'h0000_0200, 32'h1010, 64'h3, 8'h00),
         req_row(FUNC_ACCESS, 32'h0000_00FF, 32'h1010, 64'h4, 8'h00),
         req_row(FUNC_ACCESS, 32'h0000_0180, 32'h1010, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00),
         req_row(FUNC_ACCESS, 32'h0000_0180, 32'h2000, 64'h5, 8'h00),
         req_row(FUNC_READ, 32'h0, 32'h0, 64'h0, 8'h00),
         req_row(FUNC_READ, 32'h0, 32'h0, 64'h0, 8'h03),
         req_row(FUNC_READ, 32'h0, 32'h0, 64'h0, 8'h04),
         // inverted range
         csr_row(CSR_RANGE_LOW, 32'h300),
         csr_row(CSR_RANGE_HIGH, 32'h100),
         req_row(FUNC_ACCESS, 32'h0000_0200, 32'h3000, 64'h6, 8'h00),
         // whole address space, skip window wrapping through zero
         csr_row(CSR_RANGE_LOW, 32'h0),
         csr_row(CSR_RANGE_HIGH, 32'hFFFF_FFFF),
         csr_row(CSR_SKIP_LOW, 32'hFFFF_FFF0),
         csr_row(CSR_SKIP_HIGH, 32'h0000_0010),
         csr_row(CSR_RECORD_BUDGET, 32'hFFFF_FFFF),
         req_row(FUNC_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 64'h7, 8'h00),
         req_row(FUNC_ACCESS, 32'h0000_0000, 32'h0000_000F, 64'h8, 8'h00),
         req_row(FUNC_ACCESS, 32'h1234_5678, 32'h0000_0010, 64'h9, 8'h00),
         req_row(FUNC_ACCESS, 32'h8765_4321, 32'hFFFF_FFEF, 64'hA, 8'h00),
         // skip window closed, budget zero
         csr_row(CSR_SKIP_LOW, 32'h40),
         csr_row(CSR_SKIP_HIGH, 32'h40),
         csr_row(CSR_RECORD_BUDGET, 32'h0),
         req_row(FUNC_ACCESS, 32'h0000_0040, 32'h0000_0040, 64'hB, 8'h00),
         // empty range
         csr_row(CSR_RANGE_LOW, 32'h100),
         csr_row(CSR_RANGE_HIGH, 32'h100),
         req_row(FUNC_ACCESS, 32'h0000_0100, 32'h2000, 64'hC, 8'h00),
         req_row(FUNC_READ, 32'h0, 32'h0, 64'h0, 8'h01),
         req_row(FUNC_READ, 32'h0, 32'h0, 64'h0, 8'hFF),
         csr_row(CSR_WATCH_ENABLE, 32'h0),
         req_row(FUNC_ACCESS, 32'h0000_0150, 32'h2000, 64'hD, 8'h00)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(script[i].reg_idx, script[i].reg_val);
         end else begin
            typed_rsp              = '0;
            typed_rsp.in_range     = script[i].t_in_range;
            typed_rsp.log_record   = script[i].t_log;
            typed_rsp.phys_addr    = script[i].t_phys;
            typed_rsp.entries_used = script[i].t_used;
            send_request(script[i].func, script[i].addr, script[i].pc, script[i].stamp,
                         script[i].idx, script[i].typed, typed_rsp);
         end
      end

      // small range, small budget, skip window over part of a pool near the top of pc space
      lo = $urandom_range(32'h1000_0000);
      set_watch(32'h1, lo, lo + $urandom_range(16, 32'h0010_0000), 32'hFFFF_FF90,
                32'hFFFF_FFA8, $urandom_range(20, 80));
      run_phase(250, 32'hFFFF_FF80, 24);

      // budget spent from the start
      lo = $urandom_range(32'h1000_0000);
      stamp_clock = rand64();
      set_watch(32'hFFFF_FFFF, lo, lo + $urandom_range(16, 32'h0010_0000),
                32'h0004_0000 + 32'd4 * $urandom_range(10),
                32'h0004_0000 + 32'd4 * $urandom_range(11, 20), 32'h0);
      run_phase(250, 32'h0004_0000, 24);

      // everything in range, no skipping, wide pc pool to fill the table
      lo = $urandom;
      set_watch(32'h1, 32'h0, 32'hFFFF_FFFF, lo, lo, 32'hFFFF_FFFF);
      run_phase(300, $urandom & 32'hFFFF_FFFC, 2000);

      // full table: known pcs hit, new ones drop; skip window wraps through zero
      set_watch(32'h1, $urandom_range(32'h100), 32'h2000_0000, 32'hFFFF_FFF0, 32'h0000_0020,
                $urandom_range(100, 300));
      run_phase(250, 32'hFFFF_FFC0, 40);

      lo = $urandom_range(32'h1000_0000);
      set_watch(32'h1, lo, lo + $urandom_range(1, 32'h0000_1000), 32'hFFFF_FFA0,
                32'hFFFF_FFB0, $urandom_range(100));
      run_phase(50, 32'hFFFF_FF80, 64);
      tx_quiet = 1'b1;
      run_phase(150, 32'hFFFF_FF80, 64);

      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
